>>> rtl/swpr_pkg.sv
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared types and constants for the sliding window peak range core.
// ----------------------------------------------------------------------------
package swpr_pkg;

  localparam int DATA_W    = 32;
  localparam int LEN_CFG_W = 9;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // register byte addresses
  localparam logic [CFG_AW-1:0] REG_WINDOW_LEN = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

>>> rtl/sliding_window_peak_range_core.sv
// ----------------------------------------------------------------------------
// sliding_window_peak_range_core
// Keeps the newest samples of a data set in a circular memory and, per sample,
// reports max minus min of the last window_len samples and the best such range.
// ----------------------------------------------------------------------------
// channel  dir   handshake                 payload
// in_      in    in_tvalid / in_tready     tdata = sample, tlast = last
// out_     out   out_tvalid / out_tready   tdata = {best, range}, tuser = full,
//                                          tlast = last_out
// cfg_     in    APB, pready always high   window_len at byte address 0
//
// With the window full a word is scanned (one memory read per window entry, set
// by the single read port of the sample memory); otherwise the scan is skipped.
// Synchronous active-low reset clears pointer, fill count, best range; window_len resets to 1.
// The next word is taken while a finished result still waits in the output
// register; the scan finishes only once that register is free.
// ----------------------------------------------------------------------------
module sliding_window_peak_range_core #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [31:0] sample
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [63:0]                  out_tdata,  // [31:0] window_range, [63:32] best_range
  output logic                         out_tuser,  // [0] window_full
  output logic                         out_tlast,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [swpr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [swpr_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [swpr_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int DW = swpr_pkg::DATA_W;

  swpr_pkg::state_t state_r, state_nxt;

  logic [swpr_pkg::LEN_CFG_W-1:0] window_len_r;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic [FW-1:0] len_r, len_nxt;
  logic [FW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_v_r;
  logic [DW-1:0] rd_data_r;
  logic [DW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic          full_r, full_nxt;
  logic          last_r, last_nxt;
  logic          ov_r, ov_nxt;
  logic [DW-1:0] orange_r, orange_nxt, obest_r, obest_nxt;
  logic          ofull_r, ofull_nxt, olast_r, olast_nxt;

  logic [DW-1:0] mem [WINDOW_MAX];

  logic          in_acc, cfg_wr, rd_en;
  logic [31:0]   eff_len, wp_inc, start_idx;
  logic [AW-1:0] wp_inc_a;
  logic [FW-1:0] fill_inc;
  logic [DW-1:0] range_v;

  assign in_tready  = (state_r == swpr_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == swpr_pkg::REG_WINDOW_LEN);
  assign cfg_prdata = {{(swpr_pkg::CFG_DW-swpr_pkg::LEN_CFG_W){1'b0}}, window_len_r};

  assign out_tvalid = ov_r;
  assign out_tdata  = {obest_r, orange_r};
  assign out_tuser  = ofull_r;
  assign out_tlast  = olast_r;

  always_comb begin
    eff_len = {{(32-swpr_pkg::LEN_CFG_W){1'b0}}, window_len_r};
    if (eff_len == 32'd0) begin
      eff_len = 32'd1;
    end else if (eff_len > 32'(WINDOW_MAX)) begin
      eff_len = 32'(WINDOW_MAX);
    end
    wp_inc = 32'(wp_r) + 32'd1;
    if (wp_inc >= 32'(WINDOW_MAX)) begin
      wp_inc = 32'd0;
    end
    wp_inc_a  = wp_inc[AW-1:0];
    // oldest window entry, modulo the store depth
    start_idx = wp_inc + 32'(WINDOW_MAX) - eff_len;
    if (start_idx >= 32'(WINDOW_MAX)) begin
      start_idx = start_idx - 32'(WINDOW_MAX);
    end
    fill_inc = (fill_r == FW'(WINDOW_MAX)) ? fill_r : fill_r + FW'(1);
    range_v  = full_r ? (hi_r - lo_r) : '0;
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    best_nxt    = best_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    rd_addr_nxt = rd_addr_r;
    rd_en       = 1'b0;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    full_nxt    = full_r;
    last_nxt    = last_r;
    ov_nxt      = ov_r && !out_tready;
    orange_nxt  = orange_r;
    obest_nxt   = obest_r;
    ofull_nxt   = ofull_r;
    olast_nxt   = olast_r;

    // fold in the word read last cycle
    if (rd_v_r) begin
      if (rd_data_r < lo_r) lo_nxt = rd_data_r;
      if (rd_data_r > hi_r) hi_nxt = rd_data_r;
    end

    case (state_r)
      swpr_pkg::ST_IDLE: begin
        if (in_acc) begin
          wp_nxt      = wp_inc_a;
          fill_nxt    = fill_inc;
          last_nxt    = in_tlast;
          len_nxt     = eff_len[FW-1:0];
          cnt_nxt     = '0;
          rd_addr_nxt = start_idx[AW-1:0];
          lo_nxt      = '1;
          hi_nxt      = '0;
          full_nxt    = (fill_inc >= eff_len[FW-1:0]);
          state_nxt   = (fill_inc >= eff_len[FW-1:0]) ? swpr_pkg::ST_SCAN
                                                      : swpr_pkg::ST_FIN;
        end
      end
      swpr_pkg::ST_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + FW'(1);
        if (32'(rd_addr_r) + 32'd1 >= 32'(WINDOW_MAX)) begin
          rd_addr_nxt = '0;
        end else begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
        if (cnt_r + FW'(1) == len_r) begin
          state_nxt = swpr_pkg::ST_DRAIN;
        end
      end
      swpr_pkg::ST_DRAIN: begin
        state_nxt = swpr_pkg::ST_FIN;
      end
      swpr_pkg::ST_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          orange_nxt = range_v;
          obest_nxt  = (range_v > best_r) ? range_v : best_r;
          ofull_nxt  = full_r;
          olast_nxt  = last_r;
          best_nxt   = (range_v > best_r) ? range_v : best_r;
          if (last_r) begin
            best_nxt = '0;
            fill_nxt = '0;
          end
          state_nxt = swpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swpr_pkg::ST_IDLE;
      window_len_r <= swpr_pkg::LEN_CFG_W'(1);
      wp_r         <= '0;
      fill_r       <= '0;
      best_r       <= '0;
      ov_r         <= 1'b0;
      rd_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        window_len_r <= cfg_pwdata[swpr_pkg::LEN_CFG_W-1:0];
      end
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      best_r <= best_nxt;
      ov_r   <= ov_nxt;
      rd_v_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    cnt_r     <= cnt_nxt;
    rd_addr_r <= rd_addr_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    full_r    <= full_nxt;
    last_r    <= last_nxt;
    orange_r  <= orange_nxt;
    obest_r   <= obest_nxt;
    ofull_r   <= ofull_nxt;
    olast_r   <= olast_nxt;
  end

  // sample memory: write on accept, one registered read per scan cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wp_r] <= in_tdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

`ifndef ASSERT_OFF
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swpr_pkg::ST_SCAN) |-> (cnt_r < len_r))
    else $error("scan ran past window length");
  a_not_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[31:0] == 32'd0))
    else $error("range nonzero before window filled");
  a_best_ge_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:32] >= out_tdata[31:0]))
    else $error("best range below window range");
  a_drain_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swpr_pkg::ST_DRAIN) |-> rd_v_r)
    else $error("drain without pending read");
`endif

endmodule
